// ----- rtl/core/cab_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cab_pkg
// Shared types, constants and blend helper for the clipped alpha blitter.
// ----------------------------------------------------------------------------
package cab_pkg;

    // Stack of saved pen positions
    localparam int STACK_DEPTH = 256;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = STACK_AW + 1;

    // Largest usable window dimension
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // Window register reset values
    localparam logic [12:0] WIN_W_RESET = 13'd640;
    localparam logic [12:0] WIN_H_RESET = 13'd480;

    // Configuration register indexes
    localparam logic CFG_WINDOW_WIDTH  = 1'b0;
    localparam logic CFG_WINDOW_HEIGHT = 1'b1;

    // Fully opaque alpha / output alpha
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef enum logic [2:0] {
        ACT_TRANSLATE = 3'd0,
        ACT_PUSH      = 3'd1,
        ACT_POP       = 3'd2,
        ACT_IDENTITY  = 3'd3,
        ACT_BEGIN     = 3'd4,
        ACT_PIXEL     = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_FULL  = 2'd1,
        FAULT_EMPTY = 2'd2,
        FAULT_STRAY = 2'd3
    } t_fault;

    // One accepted input item
    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] amount_x;
        logic signed [15:0] amount_y;
        logic signed [15:0] amount_z;
        logic [11:0]        clip_left;
        logic [11:0]        clip_top;
        logic [12:0]        clip_width;
        logic [12:0]        clip_height;
        logic [12:0]        image_width;
        logic [12:0]        image_height;
        logic [31:0]        source_pixel;
        logic [31:0]        dest_pixel;
    } t_item;

    // One result item
    typedef struct packed {
        logic        visible;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [12:0] src_x;
        logic [12:0] src_y;
        logic [12:0] run_width;
        logic [12:0] run_height;
        logic [31:0] out_pixel;
        logic        write_pixel;
        logic        last_pixel;
        t_fault      fault_code;
    } t_result;

    // Per-channel blend: trunc((d*(255-a) + s*a) / 255).
    // Divide by 255 done as (v + (v >> 8) + 1) >> 8, exact for v <= 65025.
    function automatic logic [7:0] blend_channel(
        input logic [7:0] s,
        input logic [7:0] d,
        input logic [7:0] a
    );
        logic [7:0]  na;
        logic [15:0] v;
        logic [16:0] t;
        na = ALPHA_OPAQUE - a;
        v = 16'(d) * 16'(na) + 16'(s) * 16'(a);
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/clipped_alpha_blitter_core.sv -----
`default_nettype none
// Throughput: one item per cycle in any mix of actions, unless output stalls.
// Path: an accepted input is captured in the input register, then goes through
//   one pass of logic into the result register.
// Pen stack: 256-entry memory, top entry read ahead, bypassed on push then pop.
// Reset: synchronous, active low; clears pen, stack count, blit state and
//   handshake state. Stack memory is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// clipped_alpha_blitter_core
// 2D blitter with pen position, pen stack, rectangle clipping and ARGB blend.
// ----------------------------------------------------------------------------
module clipped_alpha_blitter_core
    import cab_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [12:0]        i_cfg_data,

    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_action,
    input  wire logic signed [15:0] i_amount_x,
    input  wire logic signed [15:0] i_amount_y,
    input  wire logic signed [15:0] i_amount_z,
    input  wire logic [11:0]        i_clip_left,
    input  wire logic [11:0]        i_clip_top,
    input  wire logic [12:0]        i_clip_width,
    input  wire logic [12:0]        i_clip_height,
    input  wire logic [12:0]        i_image_width,
    input  wire logic [12:0]        i_image_height,
    input  wire logic [31:0]        i_source_pixel,
    input  wire logic [31:0]        i_dest_pixel,

    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_visible,
    output logic [11:0]             o_dest_x,
    output logic [11:0]             o_dest_y,
    output logic [12:0]             o_src_x,
    output logic [12:0]             o_src_y,
    output logic [12:0]             o_run_width,
    output logic [12:0]             o_run_height,
    output logic [31:0]             o_out_pixel,
    output logic                    o_write_pixel,
    output logic                    o_last_pixel,
    output logic [1:0]              o_fault_code
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [12:0]          r_win_w, r_win_h;

    logic                 r_in_valid;
    t_item                r_in;
    logic                 r_out_valid;
    t_result              r_out;

    logic [31:0]          r_pen_x, r_pen_y, r_pen_z;
    logic [31:0]          n_pen_x, n_pen_y, n_pen_z;
    logic [CNT_W-1:0]     r_count, n_count;

    logic                 r_blit_active, n_blit_active;
    logic [11:0]          r_rect_x, r_rect_y, n_rect_x, n_rect_y;
    logic [12:0]          r_rect_sx, r_rect_sy, n_rect_sx, n_rect_sy;
    logic [12:0]          r_rect_w, r_rect_h, n_rect_w, n_rect_h;
    logic [11:0]          r_walk_col, r_walk_row, n_walk_col, n_walk_row;

    logic [95:0]          r_stack [STACK_DEPTH];
    logic [95:0]          r_rd_mem;
    logic [95:0]          r_byp_data;
    logic                 r_byp;
    logic [95:0]          top_data;
    logic                 mem_we;
    logic [STACK_AW-1:0]  rd_addr;
    logic [CNT_W-1:0]     rd_cnt;

    logic                 advance;
    logic                 fire;
    logic                 in_xfer;
    t_result              res;

    // begin geometry
    logic signed [35:0]   g_ww, g_wh, g_x, g_y, g_maxx, g_maxy;
    logic signed [35:0]   g_cminx, g_cmaxx, g_cminy, g_cmaxy;
    logic signed [35:0]   g_rw, g_rh, g_sx, g_sy;
    logic [12:0]          eff_w, eff_h;
    logic                 g_visible;

    // pixel walk
    logic                 walk_last, walk_eol;
    logic [7:0]           alpha;
    logic [31:0]          blended;

    // ------------------------------------------------------------------
    // Handshake: input register feeds result register
    // ------------------------------------------------------------------
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.action       <= i_action;
            r_in.amount_x     <= i_amount_x;
            r_in.amount_y     <= i_amount_y;
            r_in.amount_z     <= i_amount_z;
            r_in.clip_left    <= i_clip_left;
            r_in.clip_top     <= i_clip_top;
            r_in.clip_width   <= i_clip_width;
            r_in.clip_height  <= i_clip_height;
            r_in.image_width  <= i_image_width;
            r_in.image_height <= i_image_height;
            r_in.source_pixel <= i_source_pixel;
            r_in.dest_pixel   <= i_dest_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w <= WIN_W_RESET;
            r_win_h <= WIN_H_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_WIDTH:  r_win_w <= i_cfg_data;
                CFG_WINDOW_HEIGHT: r_win_h <= i_cfg_data;
                default:           r_win_w <= r_win_w;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Begin geometry: centre on pen + offset, flip y, clip to window
    // ------------------------------------------------------------------
    assign eff_w = (r_win_w > MAX_DIM) ? MAX_DIM : r_win_w;
    assign eff_h = (r_win_h > MAX_DIM) ? MAX_DIM : r_win_h;

    always_comb begin
        g_ww   = {23'd0, eff_w};
        g_wh   = {23'd0, eff_h};
        g_x    = {{4{r_pen_x[31]}}, r_pen_x} + {{20{r_in.amount_x[15]}}, r_in.amount_x}
               - {24'd0, r_in.clip_width[12:1]};
        g_y    = g_wh - ({{4{r_pen_y[31]}}, r_pen_y} + {{20{r_in.amount_y[15]}}, r_in.amount_y}
               + {24'd0, r_in.clip_height[12:1]});
        g_maxx = g_x + {23'd0, r_in.clip_width};
        g_maxy = g_y + {23'd0, r_in.clip_height};

        g_cminx = (g_x < 0) ? 36'sd0 : g_x;
        g_cminy = (g_y < 0) ? 36'sd0 : g_y;
        g_cmaxx = (g_maxx > g_ww) ? g_ww : g_maxx;
        g_cmaxy = (g_maxy > g_wh) ? g_wh : g_maxy;
        g_rw    = g_cmaxx - g_cminx;
        g_rh    = g_cmaxy - g_cminy;
        g_sx    = {24'd0, r_in.clip_left} + g_cminx - g_x;
        g_sy    = {24'd0, r_in.clip_top} + g_cminy - g_y;

        g_visible = (r_in.image_width != '0) && (r_in.image_height != '0)
                 && (r_in.clip_width != '0) && (r_in.clip_height != '0)
                 && (g_x < g_ww) && (g_maxx > 0) && (g_y < g_wh) && (g_maxy > 0)
                 && (g_rw != 0) && (g_rh != 0);
    end

    // ------------------------------------------------------------------
    // Pixel walk and blend
    // ------------------------------------------------------------------
    assign walk_eol  = ({1'b0, r_walk_col} == r_rect_w - 13'd1);
    assign walk_last = walk_eol && ({1'b0, r_walk_row} == r_rect_h - 13'd1);
    assign alpha     = r_in.source_pixel[31:24];

    always_comb begin
        blended = {ALPHA_OPAQUE,
                   blend_channel(r_in.source_pixel[23:16], r_in.dest_pixel[23:16], alpha),
                   blend_channel(r_in.source_pixel[15:8],  r_in.dest_pixel[15:8],  alpha),
                   blend_channel(r_in.source_pixel[7:0],   r_in.dest_pixel[7:0],   alpha)};
        if (alpha == ALPHA_OPAQUE) begin
            blended = r_in.source_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Action decode: next state and result
    // ------------------------------------------------------------------
    assign top_data = r_byp ? r_byp_data : r_rd_mem;

    always_comb begin
        n_pen_x       = r_pen_x;
        n_pen_y       = r_pen_y;
        n_pen_z       = r_pen_z;
        n_count       = r_count;
        n_blit_active = r_blit_active;
        n_rect_x      = r_rect_x;
        n_rect_y      = r_rect_y;
        n_rect_sx     = r_rect_sx;
        n_rect_sy     = r_rect_sy;
        n_rect_w      = r_rect_w;
        n_rect_h      = r_rect_h;
        n_walk_col    = r_walk_col;
        n_walk_row    = r_walk_row;
        mem_we        = 1'b0;
        res           = '0;
        res.fault_code = FAULT_NONE;

        unique case (r_in.action)
            ACT_TRANSLATE: begin
                n_pen_x = r_pen_x + {{16{r_in.amount_x[15]}}, r_in.amount_x};
                n_pen_y = r_pen_y + {{16{r_in.amount_y[15]}}, r_in.amount_y};
                n_pen_z = r_pen_z + {{16{r_in.amount_z[15]}}, r_in.amount_z};
            end
            ACT_PUSH: begin
                if (r_count >= CNT_W'(STACK_DEPTH)) begin
                    res.fault_code = FAULT_FULL;
                end else begin
                    mem_we  = fire;
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_POP: begin
                if (r_count == '0) begin
                    res.fault_code = FAULT_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_pen_x = top_data[31:0];
                    n_pen_y = top_data[63:32];
                    n_pen_z = top_data[95:64];
                end
            end
            ACT_IDENTITY: begin
                n_pen_x = '0;
                n_pen_y = '0;
                n_pen_z = '0;
            end
            ACT_BEGIN: begin
                n_blit_active = g_visible;
                if (g_visible) begin
                    n_rect_x   = g_cminx[11:0];
                    n_rect_y   = g_cminy[11:0];
                    n_rect_sx  = g_sx[12:0];
                    n_rect_sy  = g_sy[12:0];
                    n_rect_w   = g_rw[12:0];
                    n_rect_h   = g_rh[12:0];
                    n_walk_col = '0;
                    n_walk_row = '0;
                    res.visible    = 1'b1;
                    res.dest_x     = g_cminx[11:0];
                    res.dest_y     = g_cminy[11:0];
                    res.src_x      = g_sx[12:0];
                    res.src_y      = g_sy[12:0];
                    res.run_width  = g_rw[12:0];
                    res.run_height = g_rh[12:0];
                end
            end
            ACT_PIXEL: begin
                if (!r_blit_active) begin
                    res.fault_code = FAULT_STRAY;
                end else begin
                    res.dest_x     = r_rect_x + r_walk_col;
                    res.dest_y     = r_rect_y + r_walk_row;
                    res.src_x      = r_rect_sx + {1'b0, r_walk_col};
                    res.src_y      = r_rect_sy + {1'b0, r_walk_row};
                    res.last_pixel = walk_last;
                    if (alpha == ALPHA_CLEAR) begin
                        res.out_pixel   = r_in.dest_pixel;
                        res.write_pixel = 1'b0;
                    end else begin
                        res.out_pixel   = blended;
                        res.write_pixel = 1'b1;
                    end
                    // advance raster position
                    if (walk_last) begin
                        n_blit_active = 1'b0;
                        n_walk_col    = '0;
                        n_walk_row    = '0;
                    end else if (walk_eol) begin
                        n_walk_col = '0;
                        n_walk_row = r_walk_row + 12'd1;
                    end else begin
                        n_walk_col = r_walk_col + 12'd1;
                    end
                end
            end
            default: begin
                res.fault_code = FAULT_NONE;
            end
        endcase

        // state only moves when the item leaves the input register
        if (!fire) begin
            n_count = r_count;
        end
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x       <= '0;
            r_pen_y       <= '0;
            r_pen_z       <= '0;
            r_count       <= '0;
            r_blit_active <= 1'b0;
            r_rect_x      <= '0;
            r_rect_y      <= '0;
            r_rect_sx     <= '0;
            r_rect_sy     <= '0;
            r_rect_w      <= '0;
            r_rect_h      <= '0;
            r_walk_col    <= '0;
            r_walk_row    <= '0;
        end else if (fire) begin
            r_pen_x       <= n_pen_x;
            r_pen_y       <= n_pen_y;
            r_pen_z       <= n_pen_z;
            r_count       <= n_count;
            r_blit_active <= n_blit_active;
            r_rect_x      <= n_rect_x;
            r_rect_y      <= n_rect_y;
            r_rect_sx     <= n_rect_sx;
            r_rect_sy     <= n_rect_sy;
            r_rect_w      <= n_rect_w;
            r_rect_h      <= n_rect_h;
            r_walk_col    <= n_walk_col;
            r_walk_row    <= n_walk_row;
        end
    end

    // ------------------------------------------------------------------
    // Pen stack memory: read the top entry for the next item
    // ------------------------------------------------------------------
    assign rd_cnt  = n_count - CNT_W'(1);
    assign rd_addr = rd_cnt[STACK_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[r_count[STACK_AW-1:0]] <= {r_pen_z, r_pen_y, r_pen_x};
        end
        r_rd_mem <= r_stack[rd_addr];
    end

    // push then pop: take the pen just written instead of stale memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= mem_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_byp_data <= {r_pen_z, r_pen_y, r_pen_x};
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_visible     = r_out.visible;
    assign o_dest_x      = r_out.dest_x;
    assign o_dest_y      = r_out.dest_y;
    assign o_src_x       = r_out.src_x;
    assign o_src_y       = r_out.src_y;
    assign o_run_width   = r_out.run_width;
    assign o_run_height  = r_out.run_height;
    assign o_out_pixel   = r_out.out_pixel;
    assign o_write_pixel = r_out.write_pixel;
    assign o_last_pixel  = r_out.last_pixel;
    assign o_fault_code  = r_out.fault_code;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_walk_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blit_active |-> (r_rect_w != '0) && ({1'b0, r_walk_col} < r_rect_w)
                          && ({1'b0, r_walk_row} < r_rect_h))
        else $error("walk position outside active rectangle");

    a_begin_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in.action == ACT_BEGIN) && res.visible |=> r_blit_active)
        else $error("visible begin did not start a blit");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_in.action == ACT_POP) && (r_count != '0)
            |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("pop did not lower stack count");

    a_stray_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.fault_code == FAULT_STRAY) |-> !r_out.write_pixel)
        else $error("stray pixel produced a write");

endmodule
`default_nettype wire
